@@ rtl/core/sdb_pkg.sv @@
`default_nettype none

package sdb_pkg;

  // Fixed field widths of the request and response items.
  localparam int WORD_W  = 32;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int LIMIT_W = 7;

  // Default number of cells and the reset value of the capacity limit.
  localparam int                 DEPTH_DEFAULT = 64;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 7'd64;

  // Request command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_SORT       = 3'd4
  } cmd_t;

  // Response status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_BACK,
    CELL_PUSH_FRONT,
    CELL_POP_BACK,
    CELL_POP_FRONT,
    CELL_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic                     phase;
    logic signed [WORD_W-1:0] value;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/sdb_req_if.sv @@
`default_nettype none

interface sdb_req_if import sdb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sdb_rsp_if.sv @@
`default_nettype none

interface sdb_rsp_if import sdb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] popped_value;
  logic [STAT_W-1:0]        status;
  logic [COUNT_W-1:0]       element_count;

  modport source (output valid, output popped_value, output status,
                  output element_count, input ready);
  modport sink   (input valid, input popped_value, input status,
                  input element_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sdb_cell.sv @@
`default_nettype none

module sdb_cell import sdb_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cell_ctl_t                ctl,
  input  wire logic signed [WORD_W-1:0] left_data,
  input  wire logic                     left_valid,
  input  wire logic signed [WORD_W-1:0] right_data,
  input  wire logic                     right_valid,
  output logic signed [WORD_W-1:0]      data,
  output logic                          valid
);

  // A cell is the lower member of a compare pair when its parity matches the phase.
  localparam bit PARITY = 1'(IDX % 2);
  localparam bit HAS_LEFT = (IDX > 0);

  logic signed [WORD_W-1:0] data_next;
  logic                     valid_next;

  // Next contents of this cell for the broadcast operation.
  always_comb begin
    data_next  = data;
    valid_next = valid;
    case (ctl.op)
      CELL_PUSH_BACK: begin
        // Only the first empty cell takes the new word.
        if (left_valid && !valid) begin
          data_next  = ctl.value;
          valid_next = 1'b1;
        end
      end
      CELL_PUSH_FRONT: begin
        data_next  = left_data;
        valid_next = left_valid;
      end
      CELL_POP_BACK: begin
        if (valid && !right_valid) begin
          valid_next = 1'b0;
        end
      end
      CELL_POP_FRONT: begin
        data_next  = right_data;
        valid_next = right_valid;
      end
      CELL_SORT: begin
        // Odd-even transposition: lower member keeps the minimum, upper the maximum.
        if (PARITY == ctl.phase) begin
          if (valid && right_valid && (right_data < data)) begin
            data_next = right_data;
          end
        end else if (HAS_LEFT && valid && left_valid && (data < left_data)) begin
          data_next = left_data;
        end
      end
      default: begin
      end
    endcase
  end

  // Word register without reset; occupancy flag cleared by reset.
  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sortable_deque_buffer_top.sv @@
`default_nettype none
// A request's response is registered and appears in the cycle after acceptance.
// Throughput: push and pop requests are taken one per cycle while the response slot is free;
// the cell chain shifts in place. A sort request occupies the chain for DEPTH odd-even
// compare rounds, during which no request is taken.
// Reset clears the element count, the cell occupancy flags and the response slot and sets
// the capacity limit to 64; stored words are left as they are.

module sortable_deque_buffer_top import sdb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [LIMIT_W-1:0] cfg_wdata,
  sdb_req_if.sink                 req,
  sdb_rsp_if.source               rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [LIMIT_W-1:0]       capacity_limit;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [CNT_W-1:0]         sort_left;
  logic                     sorting;
  logic                     accept;
  logic                     full;
  cell_ctl_t                cell_ctl;
  logic signed [WORD_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]         cell_valid;
  logic signed [WORD_W-1:0] back_value;
  logic signed [WORD_W-1:0] popped_next;
  status_t                  status_next;

  // Request handshake: wait while sorting or while the response slot is blocked.
  assign sorting   = (sort_left != '0);
  assign req.ready = !sorting && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // Full when the count reaches the smaller of the limit and the chain length.
  assign full = (count == CNT_W'(DEPTH)) || (CMP_W'(count) >= CMP_W'(capacity_limit));

  // Word in the last occupied cell, picked out by its occupancy edge.
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid[i] && ((i == DEPTH - 1) || !cell_valid[(i + 1) % DEPTH])) begin
        back_value = back_value | cell_data[i];
      end
    end
  end

  // Command decode into the cell operation and the response fields.
  always_comb begin
    cell_ctl.op    = CELL_HOLD;
    cell_ctl.phase = sort_left[0];
    cell_ctl.value = req.push_value;
    status_next    = ST_DONE;
    popped_next    = '0;
    count_next     = count;
    if (sorting) begin
      cell_ctl.op = CELL_SORT;
    end else if (accept) begin
      unique case (cmd_t'(req.cmd))
        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            cell_ctl.op = (cmd_t'(req.cmd) == CMD_PUSH_BACK) ? CELL_PUSH_BACK
                                                               : CELL_PUSH_FRONT;
            count_next  = count + CNT_W'(1);
          end
        end
        CMD_POP_BACK: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            cell_ctl.op = CELL_POP_BACK;
            popped_next = back_value;
            count_next  = count - CNT_W'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (count == '0) begin
            status_next = ST_EMPTY;
          end else begin
            cell_ctl.op = CELL_POP_FRONT;
            popped_next = cell_data[0];
            count_next  = count - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Chain of cells; the front cell sees the pushed word as its left neighbour.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_W-1:0] left_data;
    logic                     left_valid;
    logic signed [WORD_W-1:0] right_data;
    logic                     right_valid;

    if (g == 0) begin : g_front
      assign left_data  = req.push_value;
      assign left_valid = 1'b1;
    end else begin : g_inner_l
      assign left_data  = cell_data[g-1];
      assign left_valid = cell_valid[g-1];
    end

    if (g == DEPTH - 1) begin : g_back
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_r
      assign right_data  = cell_data[g+1];
      assign right_valid = cell_valid[g+1];
    end

    sdb_cell #(.IDX(g)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (cell_ctl),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .right_data  (right_data),
      .right_valid (right_valid),
      .data        (cell_data[g]),
      .valid       (cell_valid[g])
    );
  end

  // Control registers: limit, count, sort rounds and the response flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= LIMIT_RESET;
      count          <= '0;
      sort_left      <= '0;
      rsp.valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_limit <= cfg_wdata;
      end
      count <= count_next;
      if (sorting) begin
        sort_left <= sort_left - CNT_W'(1);
      end else if (accept && (cmd_t'(req.cmd) == CMD_SORT)) begin
        sort_left <= CNT_W'(DEPTH);
      end
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Response payload, loaded with each accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.popped_value  <= popped_next;
      rsp.status        <= status_next;
      rsp.element_count <= COUNT_W'(count_next);
    end
  end

`ifndef SYNTH
  // The count always matches the number of occupied cells.
  a_count_matches : assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'($countones(cell_valid)))
    else $error("element count differs from occupied cells");

  // No request is taken while a sort is running.
  a_sort_blocks : assert property (@(posedge clk) disable iff (rst)
    sorting |-> !req.ready)
    else $error("request ready during sort");

  // A pop on an empty store answers empty and leaves the count at zero.
  a_empty_pop : assert property (@(posedge clk) disable iff (rst)
    (accept && count == '0 &&
     (req.cmd == CMD_POP_BACK || req.cmd == CMD_POP_FRONT))
    |=> (rsp.valid && rsp.status == ST_EMPTY && count == '0))
    else $error("empty pop not flagged");

  // A refused push leaves the count unchanged.
  a_full_push : assert property (@(posedge clk) disable iff (rst)
    (accept && full && !sorting &&
     (req.cmd == CMD_PUSH_BACK || req.cmd == CMD_PUSH_FRONT))
    |=> (rsp.status == ST_FULL && count == $past(count)))
    else $error("full push changed the store");
`endif

endmodule

`default_nettype wire

@@ dv/sortable_deque_buffer_top_test.sv @@
module sortable_deque_buffer_top_test;
  import sdb_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;

  // Command codes that the block must treat as no-ops.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  // Length of the long receiver hold-off, in cycles.
  localparam int LONG_HOLD = 400;

  // Largest number of mismatch lines printed.
  localparam int MAX_REPORTS = 20;

  typedef struct {
    logic [CMD_W-1:0]         code;
    logic signed [WORD_W-1:0] word;
  } request_t;

  typedef struct {
    logic signed [WORD_W-1:0] popped;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       count;
  } outcome_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  sdb_req_if req_ch ();
  sdb_rsp_if rsp_ch ();

  sortable_deque_buffer_top #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // Requests waiting to be offered, and responses still owed by the block.
  request_t pending_requests[$];
  outcome_t expected_responses[$];

  // Predictor state: the words held, front first, and the capacity limit.
  logic signed [WORD_W-1:0] held_words[$];
  logic [LIMIT_W-1:0]       limit_model;

  // Idling controls set per phase by the stimulus.
  bit tx_idle_en;
  bit rx_idle_en;
  int holds_asked;
  int holds_started;

  int errors;
  int reports;
  int n_pushes;
  int n_pops;
  int n_sorts;
  int n_spare;
  int n_full;
  int n_empty;
  int n_responses;

  int phase_limit[8];
  int phase_push_pct[8];

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run time limit.
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  // Gap length: mostly short, now and then a long stretch.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  // Stored word: extremes, small values that collide in a sort, or anything.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2, 3: return $signed($urandom_range(0, 20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Random request with a given share of pushes.
  function automatic request_t pick_request(int push_pct);
    request_t item;
    int       r;
    r = $urandom_range(0, 99);
    item.word = pick_word();
    if (r < push_pct) begin
      item.code = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end else if (r < 94) begin
      item.code = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
    end else if (r < 97) begin
      item.code = CMD_SORT;
    end else begin
      item.code = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    end
    return item;
  endfunction

  // Apply one accepted request to the deque model and record its response.
  function automatic void apply_to_model(logic [CMD_W-1:0] code,
                                         logic signed [WORD_W-1:0] word);
    outcome_t                 outcome;
    int unsigned              room;
    logic signed [WORD_W-1:0] key;
    int                       j;
    outcome.popped = '0;
    outcome.status = ST_DONE;
    room = (limit_model > DEPTH) ? DEPTH : limit_model;
    case (code)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (held_words.size() >= room) begin
          outcome.status = ST_FULL;
          n_full++;
        end else if (code == CMD_PUSH_BACK) begin
          held_words.push_back(word);
        end else begin
          held_words.push_front(word);
        end
        n_pushes++;
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (held_words.size() == 0) begin
          outcome.status = ST_EMPTY;
          n_empty++;
        end else if (code == CMD_POP_BACK) begin
          outcome.popped = held_words.pop_back();
        end else begin
          outcome.popped = held_words.pop_front();
        end
        n_pops++;
      end
      CMD_SORT: begin
        // Ascending signed order; equal words are indistinguishable.
        for (int i = 1; i < held_words.size(); i++) begin
          key = held_words[i];
          j = i;
          while (j > 0 && key < held_words[j-1]) begin
            held_words[j] = held_words[j-1];
            j--;
          end
          held_words[j] = key;
        end
        n_sorts++;
      end
      default: begin
        n_spare++;
      end
    endcase
    outcome.count = COUNT_W'(held_words.size());
    expected_responses.push_back(outcome);
  endfunction

  // Compare one response with the oldest expectation.
  task automatic check_response();
    outcome_t want;
    n_responses++;
    if (expected_responses.size() == 0) begin
      errors++;
      $display("%0t: response with none expected: popped %0d status %0d count %0d",
               $time, rsp_ch.popped_value, rsp_ch.status, rsp_ch.element_count);
      return;
    end
    want = expected_responses.pop_front();
    if (rsp_ch.popped_value !== want.popped) begin
      errors++;
      if (reports++ < MAX_REPORTS) begin
        $display("%0t: popped_value expected %0d actual %0d",
                 $time, want.popped, rsp_ch.popped_value);
      end
    end
    if (rsp_ch.status !== want.status) begin
      errors++;
      if (reports++ < MAX_REPORTS) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_ch.status);
      end
    end
    if (rsp_ch.element_count !== want.count) begin
      errors++;
      if (reports++ < MAX_REPORTS) begin
        $display("%0t: element_count expected %0d actual %0d",
                 $time, want.count, rsp_ch.element_count);
      end
    end
  endtask

  // Request driver: predicts on each accepted request, then offers the next one.
  int     tx_gap;
  request_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid      <= 1'b0;
      req_ch.cmd        <= '0;
      req_ch.push_value <= '0;
      tx_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        apply_to_model(req_ch.cmd, req_ch.push_value);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_item = pending_requests.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.cmd        <= next_item.code;
          req_ch.push_value <= next_item.word;
          if (tx_idle_en && $urandom_range(0, 2) == 0) begin
            tx_gap = pick_gap();
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each accepted response and stalls at random.
  int rx_stall;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        check_response();
      end
      if (holds_started != holds_asked) begin
        holds_started++;
        rx_stall = LONG_HOLD;
      end
      if (rx_stall != 0) begin
        rx_stall--;
        rsp_ch.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        rx_stall = pick_gap() - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic add_request(logic [CMD_W-1:0] code, logic signed [WORD_W-1:0] word);
    request_t item;
    item.code = code;
    item.word = word;
    pending_requests.push_back(item);
  endtask

  // Wait until every request has been taken and answered and any sort has finished.
  // The state is looked at just after the edge, once all updates of that edge have landed.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_requests.size() != 0 || req_ch.valid || !req_ch.ready ||
               expected_responses.size() != 0);
  endtask

  // Capacity limit write; only done while the block is idle.
  task automatic write_limit(logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_model = value;
  endtask

  // Stimulus: reset, directed cases, then random phases under several limits.
  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = '0;
    req_ch.push_value = '0;
    rsp_ch.ready      = 1'b0;
    limit_model       = LIMIT_RESET;
    tx_idle_en        = 1'b1;
    rx_idle_en        = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty pops and sort, extremes, spare codes, then sort and unload.
    add_request(CMD_POP_BACK, 32'sd0);
    add_request(CMD_POP_FRONT, 32'sd0);
    add_request(CMD_SORT, 32'sd0);
    add_request(CMD_PUSH_BACK, 32'sh7fff_ffff);
    add_request(CMD_SORT, 32'sd0);
    add_request(CMD_PUSH_FRONT, 32'sh8000_0000);
    add_request(CMD_PUSH_BACK, 32'sd0);
    add_request(CMD_PUSH_BACK, -32'sd1);
    add_request(CMD_PUSH_FRONT, 32'sd1);
    add_request(CMD_SPARE_FIRST, 32'sh5555_5555);
    add_request(CMD_SPARE_FIRST + 3'd1, 32'sd0);
    add_request(CMD_SPARE_LAST, -32'sd1);
    add_request(CMD_SORT, 32'sd0);
    add_request(CMD_POP_FRONT, 32'sd0);
    add_request(CMD_POP_BACK, 32'sd0);
    add_request(CMD_POP_FRONT, 32'sd0);
    add_request(CMD_POP_FRONT, 32'sd0);
    add_request(CMD_POP_BACK, 32'sd0);
    add_request(CMD_POP_BACK, 32'sd0);
    wait_drained();

    // A limit of zero refuses every push.
    write_limit(7'd0);
    add_request(CMD_PUSH_BACK, 32'sd5);
    add_request(CMD_PUSH_FRONT, 32'sd6);
    add_request(CMD_POP_FRONT, 32'sd0);
    wait_drained();

    // Fill ten words, then drop the limit below the count.
    write_limit(7'd64);
    for (int i = 0; i < 10; i++) add_request(CMD_PUSH_BACK, pick_word());
    wait_drained();
    write_limit(7'd3);
    add_request(CMD_PUSH_FRONT, 32'sd7);
    add_request(CMD_POP_BACK, 32'sd0);
    add_request(CMD_POP_FRONT, 32'sd0);
    add_request(CMD_PUSH_BACK, 32'sd8);
    wait_drained();

    // Random phases: limit, share of pushes and idling differ per phase.
    phase_limit    = '{64, 127, 64, 5, 1, 33, 0, 0};
    phase_push_pct = '{70, 60, 85, 50, 50, 60, 50, 40};
    phase_limit[6] = $urandom_range(2, 63);
    for (int p = 0; p < 8; p++) begin
      write_limit(LIMIT_W'(phase_limit[p]));
      tx_idle_en = (p != 2) && (p != 5);
      rx_idle_en = (p != 5);
      // Long receiver hold-off while requests keep coming, so the block fills up.
      if (p == 2) holds_asked++;
      for (int k = 0; k < (p == 7 ? 40 : 95); k++) begin
        pending_requests.push_back(pick_request(phase_push_pct[p]));
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (expected_responses.size() != 0) begin
      errors++;
      $display("%0t: %0d responses never arrived", $time, expected_responses.size());
    end
    $display("Covered %0d responses: %0d pushes (%0d refused full), %0d pops (%0d refused empty),",
             n_responses, n_pushes, n_full, n_pops, n_empty);
    $display("%0d sorts and %0d spare commands across a spread of capacity limit settings.",
             n_sorts, n_spare);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
